[rtl/core/hs_pkg.sv]
// Shared constants and types for the heap sort block.
// Used by the channel interfaces, the key RAM, the sort sequencer and the top level.
`timescale 1ns / 1ps

package hs_pkg;

  localparam int DEPTH    = 64;
  localparam int KEY_BITS = 32;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  // Child index 2p+2 of the deepest parent needs two bits more than an address.
  localparam int KID_W    = ADDR_W + 2;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [KID_W-1:0]    kid_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic load;
    key_t key;
    logic last;
    logic dropped;
  } emit_t;

endpackage

[rtl/core/hs_if.sv]
// Valid/ready channel interfaces for the heap sort block.
// Depends on hs_pkg for the key width.
`timescale 1ns / 1ps

interface hs_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [hs_pkg::KEY_BITS-1:0] key_value;
  logic                           is_final;

  modport source (output valid, key_value, is_final, input ready);
  modport sink   (input valid, key_value, is_final, output ready);
endinterface

interface hs_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [hs_pkg::KEY_BITS-1:0] sorted_key;
  logic                           last_of_run;
  logic                           keys_dropped;

  modport source (output valid, sorted_key, last_of_run, keys_dropped, input ready);
  modport sink   (input valid, sorted_key, last_of_run, keys_dropped, output ready);
endinterface

[rtl/core/heap_sort.sv]
// Heap sort block: loads a set of signed keys, heapsorts them in the key RAM
// and returns them in ascending order. Depends on hs_pkg, hs_if, hs_key_ram and
// hs_sort_seq.
//
// Each request carries one key and is taken whenever the block is loading;
// keys beyond the 64-entry store are dropped and every result of that set
// carries keys_dropped. The request with is_final set closes the set, after
// which no request is taken until the last result is in the result register.
// For n stored keys the sort runs in the single key RAM (two read ports, one
// write port): each sift-down level reads both children, then compares and
// writes the parent; a sift start reads and loads the top key; a root swap
// reads root and end key, then writes the old root to the end. Readout reads
// each key, then loads it, and waits while the result side stalls.
`timescale 1ns / 1ps

module heap_sort (
  input  logic      clk,
  input  logic      rst_n,
  hs_in_if.sink     in_ch,
  hs_out_if.source  out_ch
);

  hs_pkg::mem_req_t mem_req;
  hs_pkg::key_t     rdata_a;
  hs_pkg::key_t     rdata_b;
  hs_pkg::emit_t    emit;
  logic             out_free;

  logic             out_valid_r;
  hs_pkg::key_t     out_key_r;
  logic             out_last_r;
  logic             out_dropped_r;

  assign out_free = !out_valid_r || out_ch.ready;

  hs_sort_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_key   (in_ch.key_value),
    .in_final (in_ch.is_final),
    .out_free (out_free),
    .emit     (emit),
    .mem_req  (mem_req),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b)
  );

  hs_key_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // The sequencer loads a result only after seeing this register free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (emit.load) begin
      out_key_r     <= emit.key;
      out_last_r    <= emit.last;
      out_dropped_r <= emit.dropped;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_key   = out_key_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.keys_dropped = out_dropped_r;

endmodule

[rtl/core/hs_key_ram.sv]
// Key memory: one write port and two read ports, read data registered.
// Depends on hs_pkg for depth, widths and the request struct.
`timescale 1ns / 1ps

module hs_key_ram (
  input  logic             clk,
  input  hs_pkg::mem_req_t req,
  output hs_pkg::key_t     rdata_a,
  output hs_pkg::key_t     rdata_b
);

  hs_pkg::key_t mem [hs_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

[rtl/core/hs_sort_seq.sv]
// Sequencer that loads keys, heapsorts them in the key RAM and reads them out.
// Depends on hs_pkg; drives hs_key_ram through a request struct.
`timescale 1ns / 1ps

module hs_sort_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hs_pkg::key_t     in_key,
  input  logic             in_final,
  input  logic             out_free,
  output hs_pkg::emit_t    emit,
  output hs_pkg::mem_req_t mem_req,
  input  hs_pkg::key_t     rdata_a,
  input  hs_pkg::key_t     rdata_b
);

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_SIFT_RD   = 4'd1;
  localparam logic [3:0] ST_SIFT_LD   = 4'd2;
  localparam logic [3:0] ST_KIDS      = 4'd3;
  localparam logic [3:0] ST_CMP       = 4'd4;
  localparam logic [3:0] ST_SWAP_RD   = 4'd5;
  localparam logic [3:0] ST_SWAP_WR   = 4'd6;
  localparam logic [3:0] ST_EMIT_RD   = 4'd7;
  localparam logic [3:0] ST_EMIT_WAIT = 4'd8;

  logic [3:0]    state_r, state_nxt;
  hs_pkg::cnt_t  fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic          sorting_r, sorting_nxt;
  hs_pkg::cnt_t  heap_n_r, heap_n_nxt;
  hs_pkg::addr_t top_r, top_nxt;
  hs_pkg::addr_t parent_r, parent_nxt;
  hs_pkg::addr_t end_r, end_nxt;
  hs_pkg::addr_t emit_k_r, emit_k_nxt;
  hs_pkg::key_t  moving_r, moving_nxt;

  hs_pkg::kid_t  kid_a;
  hs_pkg::kid_t  kid_b;
  hs_pkg::kid_t  heap_n_ext;
  hs_pkg::cnt_t  fill_inc;
  hs_pkg::cnt_t  half_m1;
  hs_pkg::cnt_t  fill_m1;
  logic          take_b;
  hs_pkg::key_t  big_key;
  hs_pkg::addr_t big_addr;
  logic          sift_done;
  logic          emit_last;

  assign kid_a      = {1'b0, parent_r, 1'b1};
  assign kid_b      = kid_a + hs_pkg::KID_W'(1);
  assign heap_n_ext = hs_pkg::KID_W'(heap_n_r);
  assign fill_inc   = fill_r + hs_pkg::CNT_W'(1);
  assign fill_m1    = fill_r - hs_pkg::CNT_W'(1);
  assign take_b     = (kid_b < heap_n_ext) && ($signed(rdata_a) < $signed(rdata_b));
  assign big_key    = take_b ? rdata_b : rdata_a;
  assign big_addr   = take_b ? kid_b[hs_pkg::ADDR_W-1:0] : kid_a[hs_pkg::ADDR_W-1:0];
  assign emit_last  = (hs_pkg::CNT_W'(emit_k_r) == fill_m1);
  assign in_ready   = (state_r == ST_LOAD);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    sorting_nxt = sorting_r;
    heap_n_nxt  = heap_n_r;
    top_nxt     = top_r;
    parent_nxt  = parent_r;
    end_nxt     = end_r;
    emit_k_nxt  = emit_k_r;
    moving_nxt  = moving_r;
    half_m1     = (fill_inc >> 1) - hs_pkg::CNT_W'(1);
    sift_done   = 1'b0;
    mem_req     = '0;
    emit        = '0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (fill_r < hs_pkg::CNT_W'(hs_pkg::DEPTH)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = fill_r[hs_pkg::ADDR_W-1:0];
            mem_req.wdata = in_key;
            fill_nxt      = fill_inc;
          end else begin
            ovf_nxt  = 1'b1;
            half_m1  = (fill_r >> 1) - hs_pkg::CNT_W'(1);
          end
          if (in_final) begin
            emit_k_nxt  = '0;
            sorting_nxt = 1'b0;
            heap_n_nxt  = fill_nxt;
            top_nxt     = half_m1[hs_pkg::ADDR_W-1:0];
            if (fill_nxt < hs_pkg::CNT_W'(2)) begin
              state_nxt = ST_EMIT_RD;
            end else begin
              state_nxt = ST_SIFT_RD;
            end
          end
        end
      end
      ST_SIFT_RD: begin
        mem_req.raddr_a = top_r;
        state_nxt       = ST_SIFT_LD;
      end
      ST_SIFT_LD: begin
        moving_nxt = rdata_a;
        parent_nxt = top_r;
        state_nxt  = ST_KIDS;
      end
      ST_KIDS: begin
        if (kid_a >= heap_n_ext) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = parent_r;
          mem_req.wdata = moving_r;
          sift_done     = 1'b1;
        end else begin
          mem_req.raddr_a = kid_a[hs_pkg::ADDR_W-1:0];
          mem_req.raddr_b = kid_b[hs_pkg::ADDR_W-1:0];
          state_nxt       = ST_CMP;
        end
      end
      ST_CMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = parent_r;
        if ($signed(moving_r) > $signed(big_key)) begin
          mem_req.wdata = moving_r;
          sift_done     = 1'b1;
        end else begin
          mem_req.wdata = big_key;
          parent_nxt    = big_addr;
          state_nxt     = ST_KIDS;
        end
      end
      ST_SWAP_RD: begin
        mem_req.raddr_a = '0;
        mem_req.raddr_b = end_r;
        state_nxt       = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        // The old root goes to the end; the old end element sifts down from the root.
        mem_req.we    = 1'b1;
        mem_req.waddr = end_r;
        mem_req.wdata = rdata_a;
        moving_nxt    = rdata_b;
        parent_nxt    = '0;
        heap_n_nxt    = hs_pkg::CNT_W'(end_r);
        state_nxt     = ST_KIDS;
      end
      ST_EMIT_RD: begin
        mem_req.raddr_a = emit_k_r;
        if (out_free) begin
          state_nxt = ST_EMIT_WAIT;
        end
      end
      ST_EMIT_WAIT: begin
        emit.load    = 1'b1;
        emit.key     = rdata_a;
        emit.last    = emit_last;
        emit.dropped = ovf_r;
        if (emit_last) begin
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          emit_k_nxt = emit_k_r + hs_pkg::ADDR_W'(1);
          state_nxt  = ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // The write that finishes a sift lands before any read of the next step.
    if (sift_done) begin
      if (!sorting_r) begin
        if (top_r == '0) begin
          sorting_nxt = 1'b1;
          end_nxt     = fill_m1[hs_pkg::ADDR_W-1:0];
          state_nxt   = ST_SWAP_RD;
        end else begin
          top_nxt   = top_r - hs_pkg::ADDR_W'(1);
          state_nxt = ST_SIFT_RD;
        end
      end else begin
        if (end_r == hs_pkg::ADDR_W'(1)) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          end_nxt   = end_r - hs_pkg::ADDR_W'(1);
          state_nxt = ST_SWAP_RD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
    sorting_r <= sorting_nxt;
    heap_n_r  <= heap_n_nxt;
    top_r     <= top_nxt;
    parent_r  <= parent_nxt;
    end_r     <= end_nxt;
    emit_k_r  <= emit_k_nxt;
    moving_r  <= moving_nxt;
  end

endmodule
